>>> hw/rtl/mvs_pkg.sv
// ============================================================================
// mvs_pkg: shared types and constants of the multi-version store
// Sizes of the key and version memories, beat layouts, status codes, the
// controller states and the command/status bundles between the modules.
// ============================================================================
package mvs_pkg;

    // Store geometry
    localparam int NUM_KEYS         = 1024;
    localparam int VERSIONS_PER_KEY = 128;

    // Field widths
    localparam int KEY_W   = 10;
    localparam int DATA_W  = 32;
    localparam int TAG_W   = 18;
    localparam int STAT_W  = 2;

    // Derived memory geometry
    localparam int KEY_AW    = $clog2(NUM_KEYS);
    localparam int VER_AW    = $clog2(VERSIONS_PER_KEY);
    localparam int LEN_W     = $clog2(VERSIONS_PER_KEY + 1);
    localparam int ENTRY_W   = TAG_W + DATA_W;
    localparam int VER_DEPTH = NUM_KEYS * (2 ** VER_AW);

    // Input beat: key, value, snapshot from bit 0 up, padded to bytes
    localparam int IN_BITS   = KEY_W + DATA_W + TAG_W;
    localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int VALUE_LSB = KEY_W;
    localparam int SNAP_LSB  = KEY_W + DATA_W;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_STORED  = 2'd0,
        STAT_DROPPED = 2'd1,
        STAT_FOUND   = 2'd2,
        STAT_MISSING = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_SCAN,
        S_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic    clear_en;    // write zero to the next chain length entry
        logic    accept;      // capture the input beat, read its chain length
        logic    store;       // append a version, bump chain length and number
        logic    scan_start;  // read the newest entry of the chain
        logic    scan_step;   // read the next older entry
        logic    res_we;      // latch a result
        logic    res_hit;     // result data comes from the scanned entry
        status_t res_code;
        logic    out_load;    // move the result into the output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic kind_read;
        logic key_ok;
        logic len_full;
        logic len_zero;
        logic tag_hit;
        logic scan_last;
        logic out_free;
    } dp_stat_t;

endpackage

>>> hw/rtl/mvcc_version_store.sv
// ============================================================================
// mvcc_version_store: multi-version key-value store
// Per-key chains of versioned data with snapshot reads, one item at a time.
// ============================================================================
// Usage:
//   Slave stream (s_*) carries one item per beat: tuser is the kind (0 write,
//   1 read), tdata holds key, value and snapshot. Master stream (m_*) returns
//   exactly one result beat per item: tuser is the status, tdata the data.
//   A write goes from accept through the lookup to its result and appends the
//   value tagged with the global version number unless the chain is full. A
//   read visits up to 128 chain entries: the scan reads one version memory
//   entry per cycle, newest first, and stops at the first tag not above the
//   snapshot. The next item is taken once the result has been latched.
//   After reset the chain length memory is cleared one key per cycle, all
//   1024 keys; s_tready stays low during that pass.
//   A stalled receiver holds the result in the output register; the block
//   still accepts and works the next item and waits only to hand its result
//   over once the earlier one has been taken.
// ============================================================================
module mvcc_version_store (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mvs_pkg::S_TDATA_W-1:0]  s_tdata,  // key[9:0], value[41:10], snapshot[59:42]
    input  logic                           s_tuser,  // kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mvs_pkg::DATA_W-1:0]     m_tdata,  // read_data[31:0]
    output logic [mvs_pkg::STAT_W-1:0]     m_tuser   // status[1:0]
);

    mvs_pkg::dp_cmd_t  cmd;
    mvs_pkg::dp_stat_t stat;

    // Sequencing
    mvs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Memories and registers
    mvs_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

>>> hw/rtl/mvs_ctrl.sv
// ============================================================================
// mvs_ctrl: sequencing controller of the multi-version store
// Runs the clearing pass after reset, then takes one item at a time through
// chain length lookup, an optional newest-first scan and result hand-off.
// ============================================================================
module mvs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  mvs_pkg::dp_stat_t stat,
    output mvs_pkg::dp_cmd_t  cmd
);

    mvs_pkg::state_t state_reg;
    mvs_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mvs_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.res_code = mvs_pkg::STAT_STORED;
        s_tready     = 1'b0;
        case (state_reg)
            mvs_pkg::S_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = mvs_pkg::S_IDLE;
                end
            end
            mvs_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = mvs_pkg::S_LOOKUP;
                end
            end
            mvs_pkg::S_LOOKUP:
            begin
                if (!stat.kind_read)
                begin
                    // write: append unless the chain is full or key is bad
                    cmd.res_we = 1'b1;
                    state_next = mvs_pkg::S_DONE;
                    if (!stat.key_ok || stat.len_full)
                    begin
                        cmd.res_code = mvs_pkg::STAT_DROPPED;
                    end
                    else
                    begin
                        cmd.store    = 1'b1;
                        cmd.res_code = mvs_pkg::STAT_STORED;
                    end
                end
                else if (!stat.key_ok || stat.len_zero)
                begin
                    cmd.res_we   = 1'b1;
                    cmd.res_code = mvs_pkg::STAT_MISSING;
                    state_next   = mvs_pkg::S_DONE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = mvs_pkg::S_SCAN;
                end
            end
            mvs_pkg::S_SCAN:
            begin
                // one chain entry per cycle, newest first
                if (stat.tag_hit)
                begin
                    cmd.res_we   = 1'b1;
                    cmd.res_hit  = 1'b1;
                    cmd.res_code = mvs_pkg::STAT_FOUND;
                    state_next   = mvs_pkg::S_DONE;
                end
                else if (stat.scan_last)
                begin
                    cmd.res_we   = 1'b1;
                    cmd.res_code = mvs_pkg::STAT_MISSING;
                    state_next   = mvs_pkg::S_DONE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            mvs_pkg::S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = mvs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mvs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/mvs_datapath.sv
// ============================================================================
// mvs_datapath: memories, counters and result registers of the version store
// Holds the chain length memory, the version entry memory, the global
// version counter, the captured item and the output register.
// ============================================================================
module mvs_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [mvs_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mvs_pkg::DATA_W-1:0]     m_tdata,
    output logic [mvs_pkg::STAT_W-1:0]     m_tuser,
    input  mvs_pkg::dp_cmd_t               cmd,
    output mvs_pkg::dp_stat_t              stat
);

    localparam int VA_W = mvs_pkg::KEY_AW + mvs_pkg::VER_AW;

    // Memories
    logic [mvs_pkg::LEN_W-1:0]   len_mem [mvs_pkg::NUM_KEYS];
    logic [mvs_pkg::ENTRY_W-1:0] ver_mem [mvs_pkg::VER_DEPTH];

    // Captured item
    logic                        kind_reg;
    logic [mvs_pkg::KEY_W-1:0]   key_reg;
    logic [mvs_pkg::DATA_W-1:0]  value_reg;
    logic [mvs_pkg::TAG_W-1:0]   snap_reg;

    // Counters and control registers
    logic [mvs_pkg::KEY_AW-1:0]  clr_cnt_reg;
    logic [mvs_pkg::TAG_W-1:0]   ver_num_reg;
    logic [mvs_pkg::VER_AW-1:0]  scan_idx_reg;
    logic                        m_tvalid_reg;

    // Memory read data and results
    logic [mvs_pkg::LEN_W-1:0]   len_q;
    logic [mvs_pkg::ENTRY_W-1:0] ver_q;
    logic [mvs_pkg::STAT_W-1:0]  res_status_reg;
    logic [mvs_pkg::DATA_W-1:0]  res_data_reg;
    logic [mvs_pkg::DATA_W-1:0]  m_tdata_reg;
    logic [mvs_pkg::STAT_W-1:0]  m_tuser_reg;

    // Derived signals
    logic [mvs_pkg::KEY_AW-1:0]  in_key_idx;
    logic [mvs_pkg::KEY_AW-1:0]  key_idx;
    logic [mvs_pkg::VER_AW-1:0]  rd_idx;
    logic                        ver_re;
    logic                        len_we;
    logic [mvs_pkg::KEY_AW-1:0]  len_waddr;
    logic [mvs_pkg::LEN_W-1:0]   len_wdata;
    logic [VA_W-1:0]             ver_waddr;
    logic [VA_W-1:0]             ver_raddr;
    logic [mvs_pkg::TAG_W-1:0]   ver_tag;

    assign in_key_idx = mvs_pkg::KEY_AW'(s_tdata[mvs_pkg::KEY_W-1:0]);
    assign key_idx    = mvs_pkg::KEY_AW'(key_reg);

    // Scan address: newest entry at start, then one older each step
    assign rd_idx    = cmd.scan_start ? mvs_pkg::VER_AW'(len_q - 1'b1)
                                      : scan_idx_reg - 1'b1;
    assign ver_re    = cmd.scan_start | cmd.scan_step;
    assign ver_raddr = {key_idx, rd_idx};
    assign ver_waddr = {key_idx, len_q[mvs_pkg::VER_AW-1:0]};
    assign ver_tag   = ver_q[mvs_pkg::ENTRY_W-1:mvs_pkg::DATA_W];

    // Chain length write port shared by the clearing pass and appends
    assign len_we    = cmd.clear_en | cmd.store;
    assign len_waddr = cmd.clear_en ? clr_cnt_reg : key_idx;
    assign len_wdata = cmd.clear_en ? '0 : len_q + 1'b1;

    // Chain length memory
    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_waddr] <= len_wdata;
        end
        if (cmd.accept)
        begin
            len_q <= len_mem[in_key_idx];
        end
    end

    // Version entry memory
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            ver_mem[ver_waddr] <= {ver_num_reg, value_reg};
        end
        if (ver_re)
        begin
            ver_q <= ver_mem[ver_raddr];
        end
    end

    // Item capture and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg  <= s_tuser;
            key_reg   <= s_tdata[mvs_pkg::KEY_W-1:0];
            value_reg <= s_tdata[mvs_pkg::VALUE_LSB +: mvs_pkg::DATA_W];
            snap_reg  <= s_tdata[mvs_pkg::SNAP_LSB +: mvs_pkg::TAG_W];
        end
        if (cmd.res_we)
        begin
            res_status_reg <= cmd.res_code;
            res_data_reg   <= cmd.res_hit ? ver_q[mvs_pkg::DATA_W-1:0] : '1;
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= res_data_reg;
            m_tuser_reg <= res_status_reg;
        end
    end

    // Counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            ver_num_reg  <= '0;
            scan_idx_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_en)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.store)
            begin
                ver_num_reg <= ver_num_reg + 1'b1;
            end
            if (ver_re)
            begin
                scan_idx_reg <= rd_idx;
            end
            if (cmd.out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Status toward the controller
    always_comb
    begin
        stat.clear_last = (clr_cnt_reg == mvs_pkg::KEY_AW'(mvs_pkg::NUM_KEYS - 1));
        stat.kind_read  = kind_reg;
        stat.key_ok     = (32'(key_reg) < 32'(mvs_pkg::NUM_KEYS));
        stat.len_full   = (len_q >= mvs_pkg::LEN_W'(mvs_pkg::VERSIONS_PER_KEY));
        stat.len_zero   = (len_q == '0);
        stat.tag_hit    = (ver_tag <= snap_reg);
        stat.scan_last  = (scan_idx_reg == '0);
        stat.out_free   = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // An append never goes past the end of the chain
    a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> (!stat.len_full && stat.key_ok))
        else $error("append into a full chain");

    // Every append consumes exactly one version number
    a_num_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |=> (ver_num_reg == $past(ver_num_reg) + 1'b1))
        else $error("version number did not advance on append");

    // The scan never steps below the oldest entry
    a_scan_floor: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> !stat.scan_last)
        else $error("scan stepped past the oldest entry");

    // A result never overwrites one that is still waiting
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("output register overwritten");

endmodule
